/* design/twf_pkg.sv */
// twf_pkg: shared types and constants for the trie word filter
// used by trie_word_filter
`default_nettype none

package twf_pkg;

  localparam int unsigned NODES_DEF    = 256;
  localparam int unsigned MAX_TEXT_DEF = 64;
  localparam int unsigned ALPHABET     = 256;
  localparam logic [7:0]  MASK_RESET   = 8'd42;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_TEXT   = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_TRUNC = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INS_CHK,
    ST_INS_OUT,
    ST_S_START,
    ST_S_TXT,
    ST_S_CT,
    ST_E_RD,
    ST_E_WAIT
  } state_e;

endpackage

`default_nettype wire

/* design/twf_ram.sv */
// twf_ram: generic single write port ram with registered read
// no dependencies
`default_nettype none

module twf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

/* design/trie_word_filter.sv */
// trie_word_filter: top level, sequencer around the trie node table and text buffer
// depends on twf_pkg and twf_ram
`default_nettype none

// Banned words are inserted one byte per item (tuser 0); text bytes (tuser 1)
// are buffered until tlast, then the trie is walked from each start position
// not covered by a match, and the filtered text streams out, one mask byte per shortest match.
// After reset all NODES*256 node table entries are cleared, with tready low.
// An insert byte is then looked up in the node table, and the status item is
// handed over at the word end. A text byte is buffered; the final one starts the scan,
// which sets up each start position, then per trie step reads the text buffer,
// then the node table, both on one serial port each, and then reads each output
// item back from the text buffer. The block takes no item during scan or output.
module trie_word_filter
  import twf_pkg::*;
#(
  parameter int unsigned NODES    = NODES_DEF,
  parameter int unsigned MAX_TEXT = MAX_TEXT_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,   // mask_char
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,  // data_byte
  input  wire logic       s_axis_tlast,  // last
  input  wire logic       s_axis_tuser,  // kind
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic      [7:0] m_axis_tdata,  // out_byte
  output logic            m_axis_tlast,  // last_res
  output logic      [2:0] m_axis_tuser   // {status[1:0], any_match}
);

  localparam int unsigned NW       = $clog2(NODES);
  localparam int unsigned CAW      = NW + 8;
  localparam int unsigned CT_W     = NW + 1;
  localparam int unsigned CT_DEPTH = NODES * ALPHABET;
  localparam int unsigned TAW      = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
  localparam int unsigned TCW      = $clog2(MAX_TEXT + 1);

  state_e state_q, state_d;

  logic [CAW-1:0] clr_q, clr_d;
  logic [NW:0]    nf_q, nf_d;
  logic [NW-1:0]  cur_q, cur_d;
  logic           fail_q, fail_d;
  logic           ilast_q, ilast_d;
  logic [CAW-1:0] iaddr_q, iaddr_d;
  logic [TCW-1:0] len_q, len_d, pos_q, pos_d, p_q, p_d, n_q, n_d, k_q, k_d;
  logic           trunc_q, trunc_d;
  logic           any_q, any_d;
  logic [NW-1:0]  node_q, node_d;
  logic [7:0]     first_q, first_d;
  logic [7:0]     mask_q;
  logic           ov_q, ov_d;
  logic [7:0]     ob_q, ob_d;
  logic           ol_q, ol_d, oa_q, oa_d;
  logic [1:0]     os_q, os_d;

  // node table: entry {child is word end, child node}
  logic            ct_we;
  logic [CAW-1:0]  ct_waddr, ct_raddr;
  logic [CT_W-1:0] ct_wdata, ct_rdata;
  logic [NW-1:0]   ct_child;
  logic            ct_end;

  logic           tx_we;
  logic [TAW-1:0] tx_waddr, tx_raddr;
  logic [7:0]     tx_wdata, tx_rdata;

  logic           in_acc, out_free;
  logic [TCW-1:0] p_inc;

  assign ct_child = ct_rdata[NW-1:0];
  assign ct_end   = ct_rdata[NW];
  assign p_inc    = p_q + TCW'(1);
  assign out_free = !ov_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  twf_ram #(.WIDTH(CT_W), .DEPTH(CT_DEPTH)) u_ct (
    .clk_i  (clk_i),
    .we_i   (ct_we),
    .waddr_i(ct_waddr),
    .wdata_i(ct_wdata),
    .raddr_i(ct_raddr),
    .rdata_o(ct_rdata)
  );

  twf_ram #(.WIDTH(8), .DEPTH(MAX_TEXT)) u_tx (
    .clk_i  (clk_i),
    .we_i   (tx_we),
    .waddr_i(tx_waddr),
    .wdata_i(tx_wdata),
    .raddr_i(tx_raddr),
    .rdata_o(tx_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == CAW'(CT_DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == KIND_INSERT) begin
            if (!fail_q) state_d = ST_INS_CHK;
            else if (s_axis_tlast) state_d = ST_INS_OUT;
          end else if (s_axis_tlast) begin
            state_d = ST_S_START;
          end
        end
      end
      ST_INS_CHK: state_d = ilast_q ? ST_INS_OUT : ST_IDLE;
      ST_INS_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      ST_S_START: state_d = (pos_q >= len_q) ? ST_E_RD : ST_S_TXT;
      ST_S_TXT:   state_d = ST_S_CT;
      ST_S_CT: begin
        if (ct_child != '0 && !ct_end && p_inc < len_q) state_d = ST_S_TXT;
        else state_d = ST_S_START;
      end
      ST_E_RD: state_d = ST_E_WAIT;
      ST_E_WAIT: begin
        if (out_free) state_d = (k_q + TCW'(1) == n_q) ? ST_IDLE : ST_E_RD;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // datapath and memory control
  always_comb begin
    clr_d = clr_q; nf_d = nf_q; cur_d = cur_q; fail_d = fail_q;
    ilast_d = ilast_q; iaddr_d = iaddr_q;
    len_d = len_q; pos_d = pos_q; p_d = p_q; n_d = n_q; k_d = k_q;
    trunc_d = trunc_q; any_d = any_q; node_d = node_q; first_d = first_q;
    ov_d = ov_q && !m_axis_tready;
    ob_d = ob_q; ol_d = ol_q; oa_d = oa_q; os_d = os_q;

    ct_we    = 1'b0;
    ct_waddr = iaddr_q;
    ct_wdata = '0;
    ct_raddr = {node_q, tx_rdata};
    tx_we    = 1'b0;
    tx_waddr = n_q[TAW-1:0];
    tx_wdata = first_q;
    tx_raddr = k_q[TAW-1:0];

    unique case (state_q)
      ST_CLEAR: begin
        ct_we    = 1'b1;
        ct_waddr = clr_q;
        clr_d    = clr_q + CAW'(1);
      end
      ST_IDLE: begin
        ct_raddr = {cur_q, s_axis_tdata};
        if (in_acc) begin
          if (s_axis_tuser == KIND_INSERT) begin
            iaddr_d = {cur_q, s_axis_tdata};
            ilast_d = s_axis_tlast;
          end else begin
            if (len_q < TCW'(MAX_TEXT)) begin
              tx_we    = 1'b1;
              tx_waddr = len_q[TAW-1:0];
              tx_wdata = s_axis_tdata;
              len_d    = len_q + TCW'(1);
            end else begin
              trunc_d = 1'b1;
            end
            pos_d = '0; n_d = '0; any_d = 1'b0;
          end
        end
      end
      ST_INS_CHK: begin
        if (ct_child == '0) begin
          if (nf_q < (NW+1)'(NODES)) begin
            ct_we    = 1'b1;
            ct_wdata = {ilast_q, nf_q[NW-1:0]};
            cur_d    = nf_q[NW-1:0];
            nf_d     = nf_q + (NW+1)'(1);
          end else begin
            fail_d = 1'b1;
          end
        end else begin
          cur_d = ct_child;
          if (ilast_q) begin
            ct_we    = 1'b1;
            ct_wdata = {1'b1, ct_child};
          end
        end
      end
      ST_INS_OUT: begin
        if (out_free) begin
          ov_d = 1'b1; ob_d = '0; ol_d = 1'b1; oa_d = 1'b0;
          os_d = fail_q ? STATUS_FULL : STATUS_OK;
          cur_d = '0; fail_d = 1'b0;
        end
      end
      ST_S_START: begin
        tx_raddr = pos_q[TAW-1:0];
        p_d = pos_q; node_d = '0; k_d = '0;
      end
      ST_S_TXT: begin
        if (p_q == pos_q) first_d = tx_rdata;
      end
      ST_S_CT: begin
        tx_raddr = p_inc[TAW-1:0];
        if (ct_child != '0 && ct_end) begin
          tx_we    = 1'b1;
          tx_wdata = mask_q;
          n_d      = n_q + TCW'(1);
          any_d    = 1'b1;
          pos_d    = p_inc;
        end else if (ct_child == '0 || p_inc >= len_q) begin
          // no match from this start, or walk ran off the text end
          tx_we = 1'b1;
          n_d   = n_q + TCW'(1);
          pos_d = pos_q + TCW'(1);
        end else begin
          p_d    = p_inc;
          node_d = ct_child;
        end
      end
      ST_E_RD: ;
      ST_E_WAIT: begin
        if (out_free) begin
          ov_d = 1'b1; ob_d = tx_rdata; ol_d = (k_q + TCW'(1) == n_q);
          oa_d = any_q;
          os_d = trunc_q ? STATUS_TRUNC : STATUS_OK;
          k_d  = k_q + TCW'(1);
          if (k_q + TCW'(1) == n_q) begin
            len_d = '0; trunc_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      nf_q    <= (NW+1)'(1);
      cur_q   <= '0;
      fail_q  <= 1'b0;
      len_q   <= '0;
      trunc_q <= 1'b0;
      pos_q   <= '0;
      n_q     <= '0;
      k_q     <= '0;
      any_q   <= 1'b0;
      ov_q    <= 1'b0;
      mask_q  <= MASK_RESET;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      nf_q    <= nf_d;
      cur_q   <= cur_d;
      fail_q  <= fail_d;
      len_q   <= len_d;
      trunc_q <= trunc_d;
      pos_q   <= pos_d;
      n_q     <= n_d;
      k_q     <= k_d;
      any_q   <= any_d;
      ov_q    <= ov_d;
      if (cfg_we_i) mask_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ilast_q <= ilast_d;
    iaddr_q <= iaddr_d;
    p_q     <= p_d;
    node_q  <= node_d;
    first_q <= first_d;
    ob_q    <= ob_d;
    ol_q    <= ol_d;
    oa_q    <= oa_d;
    os_q    <= os_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = ob_q;
  assign m_axis_tlast  = ol_q;
  assign m_axis_tuser  = {os_q, oa_q};

  // in-place compaction never overtakes the read position
  a_compact: assert property (@(posedge clk_i) disable iff (!rst_ni) n_q <= pos_q)
    else $error("output index passed scan position");
  a_nodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nf_q <= (NW+1)'(NODES))
    else $error("node allocator overran table");
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !ov_q)
    else $error("output item during table clear");
  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_E_RD |-> k_q < n_q)
    else $error("emit index beyond filtered length");

endmodule

`default_nettype wire
